[hdl/bitmap_run_allocator_defines.svh]
// Assertion macros for the bitmap run allocator.
`ifndef BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BRA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/bra_pkg.sv]
package bra_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned WORD_LOG    = 5;
   localparam int unsigned BLOCK_SHIFT = 12;
   localparam int unsigned BYTES_W     = 23;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned COUNT_OUT_W = 11;
   localparam int unsigned NEED_W      = 12;
   localparam logic [31:0] BASE_RESET  = 32'hD800_0000;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_ZERO_SIZE  = 2'd2,
      ST_BAD_ADDR   = 2'd3
   } status_code_type;

   typedef struct packed {
      logic            load;
      logic            scan;
      logic            fchk;
      logic            mark;
      logic            clear;
      logic            finish;
      status_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic free_op;
      logic zero_size;
      logic no_space;
      logic bad_addr;
      logic found;
      logic last_word;
      logic start_ok;
      logic mark_last;
      logic clear_last;
   } dp_stat_type;

endpackage

[hdl/bra_ctrl.sv]
module bra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bra_pkg::dp_stat_type stat,
   output bra_pkg::dp_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SEVAL  = 7'b0001000,
      S_FCHK   = 7'b0010000,
      S_MREAD  = 7'b0100000,
      S_MWRITE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.code   = bra_pkg::ST_OK;
      busy       = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.free_op) begin
               if (stat.bad_addr) begin
                  cmd.finish = 1'b1;
                  cmd.code   = bra_pkg::ST_BAD_ADDR;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_FCHK;
               end
            end else if (stat.zero_size) begin
               cmd.finish = 1'b1;
               cmd.code   = bra_pkg::ST_ZERO_SIZE;
               state_in   = S_IDLE;
            end else if (stat.no_space) begin
               cmd.finish = 1'b1;
               cmd.code   = bra_pkg::ST_NO_SPACE;
               state_in   = S_IDLE;
            end else begin
               state_in = S_SEVAL;
            end
         end
         S_SEVAL: begin
            cmd.scan = 1'b1;
            if (stat.found) begin
               state_in = S_MREAD;
            end else if (stat.last_word) begin
               cmd.finish = 1'b1;
               cmd.code   = bra_pkg::ST_NO_SPACE;
               state_in   = S_IDLE;
            end
         end
         S_FCHK: begin
            if (!stat.start_ok) begin
               cmd.finish = 1'b1;
               cmd.code   = bra_pkg::ST_BAD_ADDR;
               state_in   = S_IDLE;
            end else begin
               cmd.fchk = 1'b1;
               state_in = S_MREAD;
            end
         end
         S_MREAD: begin
            state_in = S_MWRITE;
         end
         S_MWRITE: begin
            cmd.mark = 1'b1;
            if (stat.mark_last) begin
               cmd.finish = 1'b1;
               cmd.code   = bra_pkg::ST_OK;
               state_in   = S_IDLE;
            end else begin
               state_in = S_MREAD;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

[hdl/bra_dpath.sv]
module bra_dpath #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_mode,
   input  logic [bra_pkg::BYTES_W-1:0]            req_request_bytes,
   input  logic [bra_pkg::ADDR_W-1:0]             req_free_address,
   input  logic                                   csr_write_enable,
   input  logic [bra_pkg::ADDR_W-1:0]             csr_write_data,
   input  bra_pkg::dp_cmd_type                    cmd,
   output bra_pkg::dp_stat_type                   stat,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [bra_pkg::ADDR_W-1:0]             rsp_run_address,
   output logic [bra_pkg::COUNT_OUT_W-1:0]        rsp_run_blocks,
   output logic [bra_pkg::COUNT_OUT_W-1:0]        rsp_free_blocks
);

   localparam int NWORDS = (NUM_BLOCKS + bra_pkg::WORD_BITS - 1) / bra_pkg::WORD_BITS;
   localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int LW     = WAW + bra_pkg::WORD_LOG;
   localparam int BW     = $clog2(NUM_BLOCKS);
   localparam int CW     = $clog2(NUM_BLOCKS + 1);
   localparam int RW     = $clog2(NUM_BLOCKS + bra_pkg::WORD_BITS + 1);
   localparam int WB     = bra_pkg::WORD_BITS;
   localparam int SH     = bra_pkg::BLOCK_SHIFT;
   localparam logic [WAW-1:0] LAST_WORD = WAW'(NWORDS - 1);

   function automatic logic [WB-1:0] low_ones(input logic [5:0] k);
      logic [WB:0] t;
      t = ({{WB{1'b0}}, 1'b1} << k) - {{WB{1'b0}}, 1'b1};
      return t[WB-1:0];
   endfunction

   logic [2*WB-1:0] map_mem [NWORDS];
   logic [CW-1:0]   rl_mem  [NUM_BLOCKS];
   logic [2*WB-1:0] map_q;
   logic [CW-1:0]   rl_q;

   logic [31:0]                 base_ff;
   logic                        mode_ff;
   logic [bra_pkg::NEED_W-1:0]  need_ff;
   logic                        zero_ff;
   logic                        bad_ff;
   logic [LW-1:0]               lo_ff, lo_in;
   logic [WAW-1:0]              ptr_ff, ptr_in;
   logic [RW-1:0]               run_ff, run_in;
   logic [CW-1:0]               len_ff, len_in;
   logic [CW-1:0]               fc_ff, fc_in;
   logic                        rsp_strobe_ff;
   logic [1:0]                  rsp_status_ff;
   logic [31:0]                 rsp_addr_ff, rsp_addr_in;
   logic [bra_pkg::COUNT_OUT_W-1:0] rsp_blocks_ff, rsp_blocks_in;
   logic [bra_pkg::COUNT_OUT_W-1:0] rsp_free_ff, rsp_free_in;

   logic [bra_pkg::BYTES_W:0]   req_sum_c;
   logic [31:0]                 off_c;
   logic                        bad_c;
   logic [LW-1:0]               blk_c;
   logic [WAW-1:0]              rd_addr;
   logic [WB-1:0]               used_w;
   logic [WB-1:0]               hit;
   logic                        found;
   logic [bra_pkg::WORD_LOG-1:0] jsel;
   logic [31:0]                 start_c;
   logic [RW-1:0]               run_next;
   logic [WB-1:0]               mmask;
   logic [WB-1:0]               smask;
   logic [2*WB-1:0]             map_wdata;
   logic                        map_we;
   logic                        rl_we;
   logic                        mark_last;
   logic                        ok_fin;
   logic [31:0]                 blocks32, free32;

   assign req_sum_c = {1'b0, req_request_bytes} + (bra_pkg::BYTES_W+1)'(32'hFFF);
   assign off_c     = req_free_address - base_ff;
   assign bad_c     = (off_c[SH-1:0] != '0) ||
                      ({{SH{1'b0}}, off_c[31:SH]} >= 32'(NUM_BLOCKS));
   assign blk_c     = off_c[SH+LW-1:SH];

   assign rd_addr = (cmd.scan && ptr_ff != LAST_WORD) ? ptr_ff + WAW'(1) : ptr_ff;

   always_ff @(posedge clock) begin
      map_q <= map_mem[rd_addr];
      rl_q  <= rl_mem[lo_ff[BW-1:0]];
      if (map_we) begin
         map_mem[ptr_ff] <= map_wdata;
      end
      if (rl_we) begin
         rl_mem[lo_ff[BW-1:0]] <= len_ff;
      end
   end

   // first-fit search within one bitmap word
   always_comb begin
      logic [31:0] n32;
      logic [31:0] r32;
      logic [5:0]  k;
      logic [WB-1:0] m;
      logic [5:0]  lead;
      n32 = 32'(need_ff);
      r32 = 32'(run_ff);
      for (int i = 0; i < WB; i++) begin
         used_w[i] = map_q[i] ||
            (32'({ptr_ff, bra_pkg::WORD_LOG'(i)}) >= 32'(NUM_BLOCKS));
      end
      for (int j = 0; j < WB; j++) begin
         k = 6'(j + 1);
         if (n32 <= 32'(k)) begin
            m = low_ones(k) & ~low_ones(6'(32'(k) - n32));
            hit[j] = ((~used_w & m) == m);
         end else begin
            m = low_ones(k);
            hit[j] = ((~used_w & m) == m) && (r32 + 32'(k) >= n32);
         end
      end
      found = |hit;
      jsel  = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (hit[j]) begin
            jsel = bra_pkg::WORD_LOG'(j);
         end
      end
      start_c = 32'({ptr_ff, jsel}) + 32'd1 - n32;
      lead = 6'(WB);
      for (int i = 0; i < WB; i++) begin
         if (used_w[i]) begin
            lead = 6'(WB - 1 - i);
         end
      end
      if (used_w == '0) begin
         run_next = run_ff + RW'(WB);
      end else begin
         run_next = RW'(lead);
      end
   end

   // range mask for marking or releasing blocks of the current word
   always_comb begin
      logic [31:0] base_idx;
      logic [31:0] lo32;
      logic [31:0] hi32;
      base_idx = 32'({ptr_ff, {bra_pkg::WORD_LOG{1'b0}}});
      lo32     = 32'(lo_ff);
      hi32     = lo32 + 32'(len_ff);
      for (int i = 0; i < WB; i++) begin
         mmask[i] = (base_idx + 32'(i) >= lo32) && (base_idx + 32'(i) < hi32);
      end
      smask = '0;
      if (ptr_ff == lo_ff[LW-1:bra_pkg::WORD_LOG]) begin
         smask[lo_ff[bra_pkg::WORD_LOG-1:0]] = 1'b1;
      end
      mark_last = (base_idx + 32'(WB) >= hi32);
      if (cmd.clear) begin
         map_wdata = '0;
      end else if (mode_ff) begin
         map_wdata = {map_q[2*WB-1:WB] & ~smask, map_q[WB-1:0] & ~mmask};
      end else begin
         map_wdata = {map_q[2*WB-1:WB] | smask, map_q[WB-1:0] | mmask};
      end
   end

   assign map_we = cmd.mark | cmd.clear;
   assign ok_fin = cmd.finish && (cmd.code == bra_pkg::ST_OK);
   assign rl_we  = ok_fin && !mode_ff;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = req_mode ? blk_c[LW-1:bra_pkg::WORD_LOG] : '0;
      end else if (cmd.scan) begin
         ptr_in = found ? start_c[LW-1:bra_pkg::WORD_LOG] : ptr_ff + WAW'(1);
      end else if (cmd.mark) begin
         ptr_in = mark_last ? ptr_ff : ptr_ff + WAW'(1);
      end else if (cmd.clear) begin
         ptr_in = (ptr_ff == LAST_WORD) ? '0 : ptr_ff + WAW'(1);
      end
   end

   always_comb begin
      lo_in  = lo_ff;
      run_in = run_ff;
      len_in = len_ff;
      if (cmd.load) begin
         lo_in  = blk_c;
         run_in = '0;
      end else if (cmd.scan) begin
         if (found) begin
            lo_in  = start_c[LW-1:0];
            len_in = CW'(need_ff);
         end else begin
            run_in = run_next;
         end
      end else if (cmd.fchk) begin
         len_in = rl_q;
      end
   end

   always_comb begin
      fc_in = fc_ff;
      if (ok_fin) begin
         fc_in = mode_ff ? fc_ff + len_ff : fc_ff - len_ff;
      end
      blocks32      = ok_fin ? 32'(len_ff) : 32'd0;
      free32        = 32'(fc_in);
      rsp_blocks_in = blocks32[bra_pkg::COUNT_OUT_W-1:0];
      rsp_free_in   = free32[bra_pkg::COUNT_OUT_W-1:0];
      rsp_addr_in   = ok_fin ? base_ff + (32'(lo_ff) << SH) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= bra_pkg::BASE_RESET;
         ptr_ff        <= '0;
         fc_ff         <= CW'(NUM_BLOCKS);
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         ptr_ff        <= ptr_in;
         fc_ff         <= fc_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         need_ff <= req_sum_c[bra_pkg::BYTES_W:SH];
         zero_ff <= (req_request_bytes == '0);
         bad_ff  <= bad_c;
      end
      lo_ff  <= lo_in;
      run_ff <= run_in;
      len_ff <= len_in;
      if (cmd.finish) begin
         rsp_status_ff <= cmd.code;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_blocks_ff <= rsp_blocks_in;
         rsp_free_ff   <= rsp_free_in;
      end
   end

   always_comb begin
      stat            = '0;
      stat.free_op    = mode_ff;
      stat.zero_size  = zero_ff;
      stat.no_space   = (32'(need_ff) > 32'(fc_ff));
      stat.bad_addr   = bad_ff;
      stat.found      = found;
      stat.last_word  = (ptr_ff == LAST_WORD);
      stat.start_ok   = map_q[WB + 32'(lo_ff[bra_pkg::WORD_LOG-1:0])];
      stat.mark_last  = mark_last;
      stat.clear_last = (ptr_ff == LAST_WORD);
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_run_address = rsp_addr_ff;
   assign rsp_run_blocks  = rsp_blocks_ff;
   assign rsp_free_blocks = rsp_free_ff;

endmodule

[hdl/bitmap_run_allocator.sv]
// First-fit allocator of runs of 4096-byte blocks over a region starting
// at the base register (csr_write_data, taken when csr_write_enable is high).
// A transaction is taken when start is high and busy is low. req_mode 0
// allocates req_request_bytes rounded up to blocks; req_mode 1 releases the
// run that starts at req_free_address. Exactly one result per transaction
// appears on the rsp_ ports for one cycle with rsp_strobe high; the
// receiver cannot stall, so results are never held.
// The used bitmap sits in a memory of 32-block words, each word holding
// used bits and run-start bits. Allocation scans one word per cycle and
// then marks the run with a read-modify-write per word (S_MREAD, S_MWRITE).
// Errors found at decode end the transaction; a scan that reaches the last
// word without a fit ends it with no space; a release of an address that
// starts no run ends with a bad address, else the run is cleared word by word.
// Busy is high from the cycle after acceptance and drops in the strobe cycle.
// After reset a clearing pass over every bitmap word zeroes the bitmap
// with busy high; the free count restarts at NUM_BLOCKS.
`include "bitmap_run_allocator_defines.svh"

module bitmap_run_allocator #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [22:0] req_request_bytes,
   input  logic [31:0] req_free_address,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_run_address,
   output logic [10:0] rsp_run_blocks,
   output logic [10:0] rsp_free_blocks
);

   bra_pkg::dp_cmd_type  cmd;
   bra_pkg::dp_stat_type stat;

   bra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bra_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_request_bytes (req_request_bytes),
      .req_free_address  (req_free_address),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_run_address   (rsp_run_address),
      .rsp_run_blocks    (rsp_run_blocks),
      .rsp_free_blocks   (rsp_free_blocks)
   );

   `BRA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")
   `BRA_ASSERT_SAME(a_strobe_from_busy, clock, reset, rsp_strobe, $past(busy), "stray result")
   `BRA_ASSERT_SAME(a_err_zero, clock, reset, rsp_strobe && rsp_status != bra_pkg::ST_OK, rsp_run_address == 32'd0 && rsp_run_blocks == 11'd0, "error result not zeroed")
   `BRA_ASSERT_SAME(a_ok_blocks, clock, reset, rsp_strobe && rsp_status == bra_pkg::ST_OK && NUM_BLOCKS < 2048, rsp_run_blocks != 11'd0, "empty run on success")

endmodule

[sim/tb_bitmap_run_allocator.sv]
module tb_bitmap_run_allocator;

   localparam int NBLK = 1024;
   localparam int LIMIT_CYCLES = 900000;

   typedef struct {
      logic        mode;
      logic [22:0] bytes;
      logic [31:0] addr;
   } alloc_req_type;

   typedef struct {
      bra_pkg::status_code_type status;
      logic [31:0]              run_address;
      logic [10:0]              run_blocks;
      logic [10:0]              free_blocks;
   } alloc_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [22:0] req_request_bytes;
   logic [31:0] req_free_address;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_run_address;
   logic [10:0] rsp_run_blocks;
   logic [10:0] rsp_free_blocks;

   bitmap_run_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_request_bytes(req_request_bytes),
      .req_free_address(req_free_address),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_run_address(rsp_run_address), .rsp_run_blocks(rsp_run_blocks),
      .rsp_free_blocks(rsp_free_blocks)
   );

   // shadow allocator state
   logic [31:0] base_reg;
   bit          used_blk[NBLK];
   int unsigned run_len[NBLK];
   int unsigned free_cnt;

   alloc_req_type pending_q[$];
   alloc_rsp_type expected_q[$];

   int  errors;
   int  cycles;
   int  accepted;
   int  checked;
   int  idle_pct;
   bit  driving_on;
   bit  last_accept;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic alloc_rsp_type predict_alloc(alloc_req_type r);
      alloc_rsp_type o;
      int unsigned   need, run, first, off, blk, len;
      bit            found;
      o.status = bra_pkg::ST_OK;
      o.run_address = '0;
      o.run_blocks = '0;
      if (r.mode == 1'b0) begin
         if (r.bytes == 0) begin
            o.status = bra_pkg::ST_ZERO_SIZE;
         end else begin
            need = (r.bytes + 4095) >> 12;
            found = 0;
            run = 0;
            first = 0;
            if (need <= free_cnt) begin
               for (int i = 0; i < NBLK; i++) begin
                  if (used_blk[i]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == need) begin
                        first = i + 1 - need;
                        found = 1;
                        break;
                     end
                  end
               end
            end
            if (!found) begin
               o.status = bra_pkg::ST_NO_SPACE;
            end else begin
               for (int i = 0; i < need; i++) used_blk[first + i] = 1;
               run_len[first] = need;
               free_cnt -= need;
               o.run_address = base_reg + (first << 12);
               o.run_blocks = need[10:0];
            end
         end
      end else begin
         off = r.addr - base_reg;
         blk = off >> 12;
         if ((off & 4095) != 0 || blk >= NBLK || run_len[blk] == 0) begin
            o.status = bra_pkg::ST_BAD_ADDR;
         end else begin
            len = run_len[blk];
            for (int i = 0; i < len && blk + i < NBLK; i++) used_blk[blk + i] = 0;
            run_len[blk] = 0;
            free_cnt += len;
            o.run_address = r.addr;
            o.run_blocks = len[10:0];
         end
      end
      o.free_blocks = free_cnt[10:0];
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset || !driving_on) begin
         start <= 1'b0;
      end else if (start && !last_accept) begin
         start <= 1'b1;
      end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
         start <= 1'b1;
         req_mode <= pending_q[0].mode;
         req_request_bytes <= pending_q[0].bytes;
         req_free_address <= pending_q[0].addr;
         pending_q.pop_front();
      end else begin
         start <= 1'b0;
      end
   end

   // acceptance and result check
   always @(posedge clock) begin
      alloc_req_type r;
      alloc_rsp_type e;
      cycles++;
      last_accept = !reset && start && !busy;
      if (last_accept) begin
         r.mode = req_mode;
         r.bytes = req_request_bytes;
         r.addr = req_free_address;
         expected_q.push_back(predict_alloc(r));
         accepted++;
      end
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result status=%0d addr=%h", $time, rsp_status,
                     rsp_run_address);
            errors++;
         end else begin
            e = expected_q.pop_front();
            checked++;
            if (rsp_status !== e.status || rsp_run_address !== e.run_address ||
                rsp_run_blocks !== e.run_blocks || rsp_free_blocks !== e.free_blocks) begin
               $display("%0t: mismatch expected st=%0d addr=%h blk=%0d free=%0d",
                        $time, e.status, e.run_address, e.run_blocks, e.free_blocks);
               $display("%0t:          actual   st=%0d addr=%h blk=%0d free=%0d",
                        $time, rsp_status, rsp_run_address, rsp_run_blocks,
                        rsp_free_blocks);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (cycles >= LIMIT_CYCLES);
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic push_alloc(int unsigned nbytes);
      alloc_req_type r;
      r.mode = 1'b0;
      r.bytes = nbytes[22:0];
      r.addr = $urandom();
      pending_q.push_back(r);
   endtask

   task automatic push_release(logic [31:0] a);
      alloc_req_type r;
      r.mode = 1'b1;
      r.bytes = 23'($urandom());
      r.addr = a;
      pending_q.push_back(r);
   endtask

   task automatic drain();
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (start || busy || expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_base(logic [31:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      base_reg = v;
   endtask

   // random traffic; most releases use block-aligned addresses in the region, some random ones
   task automatic random_phase(int n);
      int unsigned sel, k, nbytes;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 50) begin
            k = $urandom_range(9);
            nbytes = (k == 0) ? $urandom_range(4194304) :
                     (k < 3) ? $urandom_range(262144, 1) : $urandom_range(16384, 1);
            push_alloc(nbytes);
         end else if (sel < 90) begin
            push_release(base_reg + ($urandom_range(NBLK - 1) << 12));
         end else if (sel < 95) begin
            push_release($urandom());
         end else begin
            push_alloc($urandom_range(1) ? 0 : $urandom_range(8388607));
         end
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      accepted = 0;
      checked = 0;
      idle_pct = 0;
      driving_on = 0;
      last_accept = 0;
      start = 1'b0;
      req_mode = 1'b0;
      req_request_bytes = '0;
      req_free_address = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      reset = 1'b1;
      base_reg = bra_pkg::BASE_RESET;
      free_cnt = NBLK;
      foreach (used_blk[i]) begin
         used_blk[i] = 0;
         run_len[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      driving_on = 1;

      // directed: reset base, all operations and errors
      push_alloc(0);
      push_alloc(1);
      push_alloc(4096);
      push_alloc(4097);
      push_alloc(4194304);
      push_alloc(8388607);
      push_release(32'hD800_0000);
      push_release(32'hD800_0001);
      push_release(32'hD800_1000);
      push_release(32'hD800_0000);
      push_release(32'hD840_0000);
      push_release(32'hFFFF_FFFF);
      push_release(32'h0000_0000);
      push_alloc(4194304);
      push_alloc(1);
      push_release(32'hD800_0000);
      push_release(32'hD800_3000);
      push_alloc(2 * 4096);
      push_alloc(4194304 - 4096);
      push_alloc(4096);
      push_release(32'hD800_1000);
      push_release(32'hD800_2000);
      drain();

      // base near the top so addresses wrap
      write_base(32'hFFFF_F000);
      push_alloc(3 * 4096);
      push_release(32'h0000_1000);
      push_release(32'hFFFF_F000);
      random_phase(110);
      drain();

      idle_pct = 67;
      write_base(32'h0000_0000);
      random_phase(110);
      drain();

      idle_pct = 14;
      write_base($urandom());
      random_phase(110);
      drain();

      idle_pct = 0;
      write_base(32'hFFFF_FFFF);
      random_phase(50);
      drain();

      idle_pct = 40;
      write_base(bra_pkg::BASE_RESET);
      random_phase(150);
      drain();

      $display("%0d transactions sent, %0d results checked over 6 base settings",
               accepted, checked);
      $display("idle ratios 0/14/40/67 percent, allocate, release and every error code");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d errors, %0d left over", errors, expected_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
